@@ hdl/xoodoo_permutation_core_defines.svh @@
// Assertion macros for the Xoodoo permutation core checkers.
`ifndef XOODOO_PERMUTATION_CORE_DEFINES_SVH
`define XOODOO_PERMUTATION_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define XP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define XP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/xoodoo_pkg.sv @@
// Package: Xoodoo state types, round constants and lane helpers.
`default_nettype none

package xoodoo_pkg;

    localparam int LANE_W     = 32;
    localparam int PLANES     = 3;
    localparam int COLS       = 4;
    localparam int STATE_W    = LANE_W * PLANES * COLS;
    localparam int MAX_ROUNDS = 12;
    localparam int RCNT_W     = 4;
    localparam int RSAT_W     = $clog2(MAX_ROUNDS + 1);
    localparam int CMP_W      = (RSAT_W > RCNT_W) ? RSAT_W : RCNT_W;

    typedef logic [LANE_W-1:0] lane_t;
    // [y][x]; lane (y, x) sits at bits (4*y + x)*32 when flattened
    typedef lane_t [PLANES-1:0][COLS-1:0] state_t;

    localparam logic [3:0] IOTA_P [7] = '{4'd1, 4'd5, 4'd7, 4'd6, 4'd3, 4'd4, 4'd2};
    localparam logic [2:0] IOTA_S [6] = '{3'd1, 3'd5, 3'd4, 3'd6, 3'd2, 3'd3};

    function automatic lane_t rotl(input lane_t v, input int unsigned n);
        int unsigned k;
        k = n % LANE_W;
        if (k == 0)
        begin
            return v;
        end
        return (v << k) | (v >> (LANE_W - k));
    endfunction

    function automatic lane_t round_const(input int unsigned j);
        lane_t base;
        base = LANE_W'(IOTA_P[j % 7] ^ 4'd8);
        return base << IOTA_S[j % 6];
    endfunction

endpackage

`default_nettype wire

@@ hdl/xoodoo_round.sv @@
// One Xoodoo round (theta, rho-west, iota, chi, rho-east) with bypass.
`default_nettype none

module xoodoo_round
    import xoodoo_pkg::*;
(
    input  wire state_t a_in,
    input  wire lane_t  rc,
    input  wire logic   en,
    output state_t      a_out
);

    always_comb
    begin
        lane_t par [COLS];
        lane_t e   [COLS];
        lane_t a   [PLANES][COLS];
        lane_t b   [PLANES][COLS];
        lane_t w1  [COLS];
        state_t r;

        for (int x = 0; x < COLS; x++)
        begin
            par[x] = a_in[0][x] ^ a_in[1][x] ^ a_in[2][x];
        end
        for (int x = 0; x < COLS; x++)
        begin
            e[x] = rotl(par[(x + 3) % COLS], 5) ^ rotl(par[(x + 3) % COLS], 14);
        end
        // theta + rho-west
        for (int x = 0; x < COLS; x++)
        begin
            a[0][x] = a_in[0][x] ^ e[x];
            w1[x]   = a_in[1][(x + 3) % COLS] ^ e[(x + 3) % COLS];
            a[2][x] = rotl(a_in[2][x] ^ e[x], 11);
        end
        for (int x = 0; x < COLS; x++)
        begin
            a[1][x] = w1[x];
        end
        // iota
        a[0][0] = a[0][0] ^ rc;
        // chi
        for (int x = 0; x < COLS; x++)
        begin
            b[0][x] = a[0][x] ^ (~a[1][x] & a[2][x]);
            b[1][x] = a[1][x] ^ (~a[2][x] & a[0][x]);
            b[2][x] = a[2][x] ^ (~a[0][x] & a[1][x]);
        end
        // rho-east
        for (int x = 0; x < COLS; x++)
        begin
            r[0][x] = b[0][x];
            r[1][x] = rotl(b[1][x], 1);
            r[2][x] = rotl(b[2][(x + 2) % COLS], 8);
        end
        a_out = en ? r : a_in;
    end

endmodule

`default_nettype wire

@@ hdl/xoodoo_permutation_core.sv @@
// Top level: Xoodoo-384 permutation, unrolled rounds between input and output registers.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata[383:0]  lanes y0_x0 .. y2_x3, 32 bits each
//  m_*      out  m_tvalid/m_tready  m_tdata[383:0]  permuted lanes, same order
//  cfg_*    in   cfg_wen            cfg_wdata[3:0]  round_count
//
// One word per cycle sustained while m_tready is high; a word passes the input register, then all
// rounds unrolled into the output register.
// Rounds not selected by round_count (saturated at 12) are bypassed.
// Reset empties both registers and sets round_count to 12.
// A stalled m_tready holds the output word; the input register still takes one more word if it is empty.
`default_nettype none

module xoodoo_permutation_core
    import xoodoo_pkg::*;
(
    input  wire  logic               clk,
    input  wire  logic               rst_n,
    input  wire  logic               s_tvalid,
    output logic                     s_tready,
    input  wire  logic [STATE_W-1:0] s_tdata,   // in_y0_x0 .. in_y0_x3, in_y1_x0 .. in_y2_x3
    output logic                     m_tvalid,
    input  wire  logic               m_tready,
    output logic [STATE_W-1:0]       m_tdata,   // out_y0_x0 .. out_y0_x3, out_y1_x0 .. out_y2_x3
    input  wire  logic               cfg_wen,
    input  wire  logic [RCNT_W-1:0]  cfg_wdata  // round_count
);

    logic              in_valid_reg;
    logic              in_valid_next;
    state_t            in_data_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    state_t            out_data_reg;
    logic [RCNT_W-1:0] round_count_reg;
    logic [RCNT_W-1:0] round_count_next;
    logic              adv;
    logic [CMP_W-1:0]  cnt_ext;
    logic [CMP_W-1:0]  rounds_sat;
    state_t            chain [MAX_ROUNDS+1];

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign in_valid_next    = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next   = adv ? in_valid_reg : out_valid_reg;
    assign round_count_next = cfg_wen ? cfg_wdata : round_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            round_count_reg <= RCNT_W'(MAX_ROUNDS);
        end
        else
        begin
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            round_count_reg <= round_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= state_t'(s_tdata);
        end
        if (adv && in_valid_reg)
        begin
            out_data_reg <= chain[MAX_ROUNDS];
        end
    end

    assign cnt_ext    = CMP_W'(round_count_reg);
    assign rounds_sat = (cnt_ext > CMP_W'(MAX_ROUNDS)) ? CMP_W'(MAX_ROUNDS) : cnt_ext;

    assign chain[0] = in_data_reg;

    // stage i runs round index MAX_ROUNDS-1-i, highest index first
    for (genvar i = 0; i < MAX_ROUNDS; i++)
    begin : g_round
        xoodoo_round u_round (
            .a_in  (chain[i]),
            .rc    (round_const(MAX_ROUNDS - 1 - i)),
            .en    (rounds_sat > CMP_W'(MAX_ROUNDS - 1 - i)),
            .a_out (chain[i+1])
        );
    end

endmodule

`default_nettype wire

@@ hdl/xoodoo_checker.sv @@
// Port-level checker for the Xoodoo permutation core, bound to the top level.
`default_nettype none

`include "xoodoo_permutation_core_defines.svh"

module xoodoo_checker
    import xoodoo_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               s_tvalid,
    input wire logic               s_tready,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [STATE_W-1:0] m_tdata
);

    logic s_acc;

    assign s_acc = s_tvalid && s_tready;

    // output word holds while stalled
    `XP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "output word changed while stalled")

    // input only backs up when both registers are full and the output is stalled
    `XP_ASSERT_NOW(a_ready_backpressure, !s_tready, m_tvalid && !m_tready,
        "s_tready low without output stall")

    // a fresh output word comes from an earlier accepted input word
    `XP_ASSERT_NOW(a_out_source, $rose(m_tvalid), $past(s_acc, 2),
        "output word without matching input")

    // after an output word is taken with no input offered, input is open
    `XP_ASSERT_NEXT(a_drain_ready, m_tvalid && m_tready && !s_tvalid, s_tready,
        "input blocked after drain")

endmodule

bind xoodoo_permutation_core xoodoo_checker u_xoodoo_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);

`default_nettype wire

@@ test/xoodoo_perm_checker.sv @@
// Checker for the Xoodoo permutation core: predicts every output word and compares it lane by lane.
module xoodoo_perm_checker
    import xoodoo_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [STATE_W-1:0] s_tdata,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [STATE_W-1:0] m_tdata,
    input  logic               cfg_wen,
    input  logic [RCNT_W-1:0]  cfg_wdata,
    output int                 fail_count,
    output int                 pending
);

    localparam logic [3:0] RC_BASE  [7] = '{4'd1, 4'd5, 4'd7, 4'd6, 4'd3, 4'd4, 4'd2};
    localparam int         RC_SHIFT [6] = '{1, 5, 4, 6, 2, 3};

    logic [RCNT_W-1:0] round_count;
    state_t            expected_states [$];
    int                words_seen;

    initial
    begin
        fail_count = 0;
        words_seen = 0;
    end

    task automatic report_mismatch(input string msg);
        if (fail_count < 100)
        begin
            $display("%0t ERROR %s", $time, msg);
        end
        fail_count++;
    endtask

    // only called with 0 < n < 32
    function automatic lane_t rol(input lane_t v, input int n);
        return (v << n) | (v >> (LANE_W - n));
    endfunction

    function automatic state_t permute_state(input state_t din, input logic [RCNT_W-1:0] rcount);
        state_t a;
        state_t b;
        lane_t  par [COLS];
        lane_t  eff [COLS];
        lane_t  tmp [COLS];
        int     rounds;
        a = din;
        rounds = (rcount > MAX_ROUNDS) ? MAX_ROUNDS : int'(rcount);
        for (int j = rounds - 1; j >= 0; j--)
        begin
            // theta
            for (int x = 0; x < COLS; x++)
            begin
                par[x] = a[0][x] ^ a[1][x] ^ a[2][x];
            end
            for (int x = 0; x < COLS; x++)
            begin
                eff[x] = rol(par[(x + 3) % COLS], 5) ^ rol(par[(x + 3) % COLS], 14);
            end
            for (int y = 0; y < PLANES; y++)
            begin
                for (int x = 0; x < COLS; x++)
                begin
                    a[y][x] ^= eff[x];
                end
            end
            // rho-west
            for (int x = 0; x < COLS; x++)
            begin
                tmp[x] = a[1][(x + 3) % COLS];
            end
            for (int x = 0; x < COLS; x++)
            begin
                a[1][x] = tmp[x];
                a[2][x] = rol(a[2][x], 11);
            end
            // iota
            a[0][0] ^= (lane_t'(RC_BASE[j % 7] ^ 4'd8)) << RC_SHIFT[j % 6];
            // chi
            for (int x = 0; x < COLS; x++)
            begin
                b[0][x] = ~a[1][x] & a[2][x];
                b[1][x] = ~a[2][x] & a[0][x];
                b[2][x] = ~a[0][x] & a[1][x];
            end
            a = a ^ b;
            // rho-east
            for (int x = 0; x < COLS; x++)
            begin
                tmp[x] = a[2][(x + 2) % COLS];
            end
            for (int x = 0; x < COLS; x++)
            begin
                a[1][x] = rol(a[1][x], 1);
                a[2][x] = rol(tmp[x], 8);
            end
        end
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        state_t got;
        state_t want;
        if (!rst_n)
        begin
            round_count <= RCNT_W'(MAX_ROUNDS);
            expected_states.delete();
            pending <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_states.insert(expected_states.size(),
                                       permute_state(s_tdata, round_count));
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_states.size() == 0)
                begin
                    report_mismatch($sformatf("output word %0d arrived with nothing expected",
                                              words_seen));
                end
                else
                begin
                    got  = m_tdata;
                    want = expected_states.pop_front();
                    for (int y = 0; y < PLANES; y++)
                    begin
                        for (int x = 0; x < COLS; x++)
                        begin
                            if (got[y][x] !== want[y][x])
                            begin
                                report_mismatch($sformatf(
                                    "word %0d lane y%0d_x%0d: got %h expected %h",
                                    words_seen, y, x, got[y][x], want[y][x]));
                            end
                        end
                    end
                end
                words_seen++;
            end
            if (cfg_wen)
            begin
                round_count <= cfg_wdata;
            end
            pending <= expected_states.size();
        end
    end

endmodule

@@ test/tb_xoodoo_permutation_core.sv @@
// Testbench top for the Xoodoo permutation core: reset, round-count settings, stimulus and verdict.
module tb_xoodoo_permutation_core;
    import xoodoo_pkg::*;

    typedef enum int {
        PAT_ZERO,
        PAT_ONES,
        PAT_LOW_BIT,
        PAT_HIGH_BIT,
        PAT_ALT_A,
        PAT_ALT_5,
        PAT_RAMP,
        PAT_RANDOM
    } pattern_e;

    localparam int          PHASE_WORDS = 220;
    localparam int          HOLD_CYCLES = 300;
    localparam logic [3:0]  ROUND_PLAN [8] = '{4'd15, 4'd0, 4'd12, 4'd1,
                                               4'd13, 4'd6, 4'd11, 4'd7};

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [STATE_W-1:0] s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [STATE_W-1:0] m_tdata;
    logic               cfg_wen;
    logic [RCNT_W-1:0]  cfg_wdata;

    int fail_count;
    int pending;
    int idle_pct;
    int stall_pct;
    int holds_req;
    int holds_done;

    xoodoo_permutation_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    xoodoo_perm_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off whenever one is requested
    initial
    begin
        m_tready   = 1'b0;
        holds_done = 0;
        forever
        begin
            @(posedge clk);
            if (holds_done != holds_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done = holds_done + 1;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic state_t make_word(input pattern_e kind);
        state_t w;
        for (int y = 0; y < PLANES; y++)
        begin
            for (int x = 0; x < COLS; x++)
            begin
                case (kind)
                    PAT_ZERO:     w[y][x] = '0;
                    PAT_ONES:     w[y][x] = '1;
                    PAT_LOW_BIT:  w[y][x] = (y == 0 && x == 0) ? 32'h0000_0001 : 32'h0;
                    PAT_HIGH_BIT: w[y][x] = (y == 2 && x == 3) ? 32'h8000_0000 : 32'h0;
                    PAT_ALT_A:    w[y][x] = 32'hAAAA_AAAA;
                    PAT_ALT_5:    w[y][x] = 32'h5555_5555;
                    PAT_RAMP:     w[y][x] = 32'h0101_0101 * (4 * y + x + 1);
                    default:      w[y][x] = $urandom;
                endcase
            end
        end
        return w;
    endfunction

    task automatic send_word(input state_t w);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge clk); while (!s_tready);
    endtask

    // wait until every predicted word has come out
    task automatic drain;
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic set_round_count(input logic [RCNT_W-1:0] value);
        drain();
        repeat (4) @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen   <= 1'b0;
    endtask

    initial
    begin
        pattern_e kind;
        logic [RCNT_W-1:0] rc;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wen   = 1'b0;
        cfg_wdata = '0;
        idle_pct  = 0;
        stall_pct = 0;
        holds_req = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset round count first
        for (int k = PAT_ZERO; k <= PAT_RAMP; k++)
        begin
            send_word(make_word(pattern_e'(k)));
        end
        // zero rounds pass the state through
        set_round_count(4'd0);
        send_word(make_word(PAT_ONES));
        send_word(make_word(PAT_RAMP));
        set_round_count(4'd1);
        send_word(make_word(PAT_ZERO));
        send_word(make_word(PAT_LOW_BIT));
        // counts above the maximum saturate
        set_round_count(4'd13);
        send_word(make_word(PAT_ZERO));
        send_word(make_word(PAT_RAMP));
        set_round_count(4'd15);
        send_word(make_word(PAT_ONES));

        for (int ph = 0; ph < 8; ph++)
        begin
            rc = (ph == 7) ? RCNT_W'($urandom_range(15)) : ROUND_PLAN[ph];
            set_round_count(rc);
            case (ph % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 52;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 52;
                end
                default:
                begin
                    idle_pct  = 12;
                    stall_pct = 12;
                end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (ph == 2 && n == 100)
                begin
                    holds_req = holds_req + 1;
                end
                if (ph == 5 && n == 110)
                begin
                    drain();
                end
                kind = ($urandom_range(7) == 0) ? pattern_e'($urandom_range(PAT_RAMP))
                                                 : PAT_RANDOM;
                send_word(make_word(kind));
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
